>>> src/lrb_pkg.sv
`timescale 1ns / 1ps

package lrb_pkg;

    // Fixed field widths of the ports
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 16;
    localparam int IDX_W     = 13;
    localparam int OKIND_W   = 3;
    localparam int LEVEL_W   = 3;
    localparam int WC_W      = 14;
    localparam int CLEVEL_W  = 4;

    // Depth defaults and queue sizing
    localparam int DEFAULT_LOG_DEPTH = 8192;
    localparam int QUEUE_DEPTH       = 4;
    localparam int PLAN_SLOTS        = 6;
    localparam int PLAN_W            = 3;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_LT   = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT   = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEVEN = 8'h37;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECENT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // Result kinds
    localparam logic [OKIND_W-1:0] OUT_CONSOLE = 3'd0;
    localparam logic [OKIND_W-1:0] OUT_READ    = 3'd1;
    localparam logic [OKIND_W-1:0] OUT_EMPTY   = 3'd2;
    localparam logic [OKIND_W-1:0] OUT_RECENT  = 3'd3;
    localparam logic [OKIND_W-1:0] OUT_RANGE   = 3'd4;

    // Configuration register indexes
    localparam logic CFG_CONSOLE = 1'b0;
    localparam logic CFG_DEFAULT = 1'b1;

    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,
        OP_NEXT   = 2'd1,
        OP_RECENT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // One queued operation for the back end
    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic              echo;
        logic [LEVEL_W-1:0] level;
        logic              last;
        logic [REQ_W-1:0]  req;
        logic [IDX_W-1:0]  idx;
    } uop_t;

endpackage

>>> src/log_ring_buffer_with_level_tags_core.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Words
// s_*       | in        | s_valid / s_ready  | kind, data_byte, end_of_call, request, index
// m_*       | out       | m_valid / m_ready  | out_kind, out_byte, line_level, window, last
// cfg_*     | in        | cfg_valid/cfg_ready| cfg_index (0 console, 1 default), cfg_data
//
// The front accepts a word, then issues one operation per cycle into a
// four-entry queue while it is not full; an append issues zero to six stores
// (six when a default tag goes in front of held bytes), others issue one.
// While its output is free, the back executes one queued operation per cycle
// on the single-port log RAM; next and recent reads add a read state (registered RAM).
// A waiting result stalls the back only; the front keeps filling the queue
// until it is full and then holds s_ready low.
// Reset is synchronous; the log RAM is not cleared and needs no sweep.

module log_ring_buffer_with_level_tags_core import lrb_pkg::*; #(
    parameter int LOG_DEPTH = DEFAULT_LOG_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [BYTE_W-1:0]   s_data_byte,
    input  logic                s_end_of_call,
    input  logic [REQ_W-1:0]    s_request_count,
    input  logic [IDX_W-1:0]    s_recent_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OKIND_W-1:0]  m_out_kind,
    output logic [BYTE_W-1:0]   m_out_byte,
    output logic [LEVEL_W-1:0]  m_line_level,
    output logic [WC_W-1:0]     m_window_count,
    output logic                m_last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [CLEVEL_W-1:0] cfg_data
);

    logic [CLEVEL_W-1:0] console_level_reg;
    logic [LEVEL_W-1:0]  default_level_reg;
    logic                q_push, q_full, q_pop, q_empty;
    uop_t                q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            console_level_reg <= CLEVEL_W'(7);
            default_level_reg <= LEVEL_W'(4);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CONSOLE: console_level_reg <= cfg_data;
                CFG_DEFAULT: default_level_reg <= cfg_data[LEVEL_W-1:0];
                default:     console_level_reg <= console_level_reg;
            endcase
        end
    end

    lrb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_data_byte     (s_data_byte),
        .s_end_of_call   (s_end_of_call),
        .s_request_count (s_request_count),
        .s_recent_index  (s_recent_index),
        .console_level   (console_level_reg),
        .default_level   (default_level_reg),
        .q_push          (q_push),
        .q_wdata         (q_wdata),
        .q_full          (q_full)
    );

    lrb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    lrb_back #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_byte     (m_out_byte),
        .m_line_level   (m_line_level),
        .m_window_count (m_window_count),
        .m_last         (m_last)
    );

    // Reads and status answers are always the single, last result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind != OUT_CONSOLE) |-> m_last)
        else $error("read result without last");

    // Status answers carry no byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind == OUT_EMPTY || m_out_kind == OUT_RANGE))
            |-> (m_out_byte == '0))
        else $error("status result carries a byte");

    // Only console bytes carry a line level
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind != OUT_CONSOLE) |-> (m_line_level == '0))
        else $error("line level on non-console result");

    // Nothing is pushed while a new word is being taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !q_push)
        else $error("front issued while idle");

endmodule

>>> src/lrb_ram.sv
`timescale 1ns / 1ps

module lrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/lrb_queue.sv
`timescale 1ns / 1ps

module lrb_queue import lrb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  uop_t wdata,
    output logic full,
    input  logic pop,
    output uop_t rdata,
    output logic empty
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);

    uop_t             mem_reg [QUEUE_DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg;
    logic [QA_W-1:0]  rd_ptr_reg;
    logic [QA_W:0]    count_reg;

    assign full  = (count_reg == (QA_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Hold entries
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty)) begin
                count_reg <= count_reg + 1'b1;
            end else if (!(push && !full) && (pop && !empty)) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/lrb_front.sv
`timescale 1ns / 1ps

module lrb_front import lrb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [BYTE_W-1:0]   s_data_byte,
    input  logic                s_end_of_call,
    input  logic [REQ_W-1:0]    s_request_count,
    input  logic [IDX_W-1:0]    s_recent_index,
    input  logic [CLEVEL_W-1:0] console_level,
    input  logic [LEVEL_W-1:0]  default_level,
    output logic                q_push,
    output uop_t                q_wdata,
    input  logic                q_full
);

    // Line tracking state
    logic                in_line_reg, in_line_next;
    logic [LEVEL_W-1:0]  cur_level_reg, cur_level_next;
    logic [BYTE_W-1:0]   la0_reg, la0_next;
    logic [BYTE_W-1:0]   la1_reg, la1_next;
    logic [1:0]          la_used_reg, la_used_next;

    // Operation plan of the accepted word
    logic [BYTE_W-1:0]     plan_byte_reg [PLAN_SLOTS];
    logic [BYTE_W-1:0]     plan_byte_next [PLAN_SLOTS];
    logic [PLAN_SLOTS-1:0] plan_text_reg, plan_text_next;
    logic [PLAN_W-1:0]     plan_cnt_reg, plan_cnt_next;
    logic [PLAN_W-1:0]     plan_pos_reg;
    op_t                   plan_op_reg, plan_op_next;
    logic                  plan_echo_reg;
    logic [LEVEL_W-1:0]    plan_level_reg;
    logic [REQ_W-1:0]      plan_req_reg;
    logic [IDX_W-1:0]      plan_idx_reg;

    logic busy;
    logic accept;

    assign busy    = (plan_pos_reg != plan_cnt_reg);
    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;

    // Classify the word: tag check and plan of stores
    always_comb begin
        logic              ok;
        logic              has_tag;
        logic [1:0]        nx;
        logic [BYTE_W-1:0] t0, t1, t2, x0, x1, x2, deftag;
        logic [2:0]        tmask;

        in_line_next   = in_line_reg;
        cur_level_next = cur_level_reg;
        la0_next       = la0_reg;
        la1_next       = la1_reg;
        la_used_next   = la_used_reg;
        has_tag        = 1'b0;
        nx             = 2'd0;
        deftag         = {CH_ZERO[BYTE_W-1:LEVEL_W], default_level};
        t0             = CH_LT;
        t1             = deftag;
        t2             = CH_GT;

        case (la_used_reg)
            2'd0:    ok = (s_data_byte == CH_LT);
            2'd1:    ok = (s_data_byte >= CH_ZERO) && (s_data_byte <= CH_SEVEN);
            default: ok = (s_data_byte == CH_GT);
        endcase

        // Held bytes go first, then the current byte
        x0 = (la_used_reg != 2'd0) ? la0_reg : s_data_byte;
        x1 = (la_used_reg == 2'd2) ? la1_reg : s_data_byte;
        x2 = s_data_byte;

        if (in_line_reg) begin
            nx           = 2'd1;
            x0           = s_data_byte;
            in_line_next = (s_data_byte != CH_NL);
        end else if (ok && la_used_reg == 2'd2) begin
            has_tag        = 1'b1;
            t0             = la0_reg;
            t1             = la1_reg;
            t2             = s_data_byte;
            cur_level_next = la1_reg[LEVEL_W-1:0];
            in_line_next   = 1'b1;
            la_used_next   = 2'd0;
        end else if (ok && !s_end_of_call) begin
            if (la_used_reg == 2'd0) begin
                la0_next = s_data_byte;
            end else begin
                la1_next = s_data_byte;
            end
            la_used_next = la_used_reg + 2'd1;
        end else begin
            has_tag        = 1'b1;
            cur_level_next = default_level;
            nx             = la_used_reg + 2'd1;
            la_used_next   = 2'd0;
            in_line_next   = (s_data_byte != CH_NL);
        end

        tmask = {nx >= 2'd3, nx >= 2'd2, nx >= 2'd1};

        plan_byte_next[0] = has_tag ? t0 : x0;
        plan_byte_next[1] = has_tag ? t1 : x1;
        plan_byte_next[2] = has_tag ? t2 : x2;
        plan_byte_next[3] = x0;
        plan_byte_next[4] = x1;
        plan_byte_next[5] = x2;

        plan_text_next = has_tag ? {tmask, 3'b000} : {3'b000, tmask};
        plan_cnt_next  = has_tag ? (PLAN_W'(3) + PLAN_W'(nx)) : PLAN_W'(nx);

        case (s_kind)
            KIND_NEXT:   plan_op_next = OP_NEXT;
            KIND_RECENT: plan_op_next = OP_RECENT;
            KIND_CLEAR:  plan_op_next = OP_CLEAR;
            default:     plan_op_next = OP_STORE;
        endcase

        if (s_kind != KIND_APPEND) begin
            plan_cnt_next  = PLAN_W'(1);
            plan_text_next = '0;
        end
    end

    // Latch the plan on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            plan_byte_reg  <= plan_byte_next;
            plan_text_reg  <= plan_text_next;
            plan_op_reg    <= plan_op_next;
            plan_echo_reg  <= ({1'b0, cur_level_next} < console_level);
            plan_level_reg <= cur_level_next;
            plan_req_reg   <= s_request_count;
            plan_idx_reg   <= s_recent_index;
        end
    end

    // Advance line state and issue pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_line_reg   <= 1'b0;
            cur_level_reg <= '0;
            la0_reg       <= '0;
            la1_reg       <= '0;
            la_used_reg   <= '0;
            plan_cnt_reg  <= '0;
            plan_pos_reg  <= '0;
        end else begin
            if (accept) begin
                plan_cnt_reg <= plan_cnt_next;
                plan_pos_reg <= '0;
                if (s_kind == KIND_APPEND) begin
                    in_line_reg   <= in_line_next;
                    cur_level_reg <= cur_level_next;
                    la0_reg       <= la0_next;
                    la1_reg       <= la1_next;
                    la_used_reg   <= la_used_next;
                end
            end else if (q_push) begin
                plan_pos_reg <= plan_pos_reg + 1'b1;
            end
        end
    end

    // Issue one operation per cycle while the queue is not full
    assign q_push        = busy && !q_full;
    assign q_wdata.op    = plan_op_reg;
    assign q_wdata.data  = plan_byte_reg[plan_pos_reg];
    assign q_wdata.echo  = plan_echo_reg && plan_text_reg[plan_pos_reg];
    assign q_wdata.level = plan_level_reg;
    assign q_wdata.last  = q_wdata.echo && (plan_pos_reg == plan_cnt_reg - 1'b1);
    assign q_wdata.req   = plan_req_reg;
    assign q_wdata.idx   = plan_idx_reg;

endmodule

>>> src/lrb_back.sv
`timescale 1ns / 1ps

module lrb_back import lrb_pkg::*; #(
    parameter int LOG_DEPTH = DEFAULT_LOG_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  uop_t                q_rdata,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OKIND_W-1:0]  m_out_kind,
    output logic [BYTE_W-1:0]   m_out_byte,
    output logic [LEVEL_W-1:0]  m_line_level,
    output logic [WC_W-1:0]     m_window_count,
    output logic                m_last
);

    localparam int AW    = $clog2(LOG_DEPTH);
    localparam int CW    = $clog2(LOG_DEPTH + 1);
    localparam int CMP_W = (CW > REQ_W) ? CW : REQ_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(LOG_DEPTH - 1);

    typedef enum logic [1:0] {
        BK_RUN  = 2'b01,
        BK_READ = 2'b10
    } bk_state_t;

    bk_state_t          state_reg, state_next;
    logic [AW-1:0]      oldest_reg, oldest_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      recent_reg, recent_next;
    logic [OKIND_W-1:0] pend_kind_reg, pend_kind_next;
    logic [WC_W-1:0]    pend_wc_reg, pend_wc_next;

    logic               m_valid_reg, m_valid_next;
    logic [OKIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [WC_W-1:0]    wc_reg, wc_next;
    logic               last_reg, last_next;
    logic               load;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic               out_free;
    logic [CW-1:0]      win_cnt;
    logic               out_of_range;
    logic [AW-1:0]      recent_pos;

    lrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (q_rdata.data),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == BK_RUN) && !q_empty && out_free;

    // Clamp the recent window and locate the indexed byte
    always_comb begin
        logic [CMP_W-1:0] req_c, rec_c, cnt_c;
        logic [CW-1:0]    back, wr_c;

        req_c        = CMP_W'(q_rdata.req);
        rec_c        = CMP_W'(recent_reg);
        cnt_c        = (req_c < rec_c) ? req_c : rec_c;
        win_cnt      = CW'(cnt_c);
        out_of_range = (CMP_W'(q_rdata.idx) >= cnt_c);
        back         = win_cnt - CW'(q_rdata.idx);
        wr_c         = CW'(wr_ptr_reg);
        if (wr_c >= back) begin
            recent_pos = AW'(wr_c - back);
        end else begin
            recent_pos = AW'(DEPTH_C - (back - wr_c));
        end
    end

    // Carry out the head operation
    always_comb begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        recent_next    = recent_reg;
        pend_kind_next = pend_kind_reg;
        pend_wc_next   = pend_wc_reg;
        ram_we         = 1'b0;
        ram_addr       = wr_ptr_reg;
        load           = 1'b0;
        kind_next      = OUT_CONSOLE;
        byte_next      = '0;
        level_next     = '0;
        wc_next        = '0;
        last_next      = 1'b1;

        case (state_reg)
            BK_RUN: begin
                if (q_pop) begin
                    case (q_rdata.op)
                        OP_STORE: begin
                            ram_we      = 1'b1;
                            wr_ptr_next = (wr_ptr_reg == LAST_A) ? '0 : wr_ptr_reg + 1'b1;
                            if (fill_reg < DEPTH_C) begin
                                fill_next = fill_reg + 1'b1;
                            end else begin
                                oldest_next = (oldest_reg == LAST_A) ? '0 : oldest_reg + 1'b1;
                            end
                            if (recent_reg < DEPTH_C) begin
                                recent_next = recent_reg + 1'b1;
                            end
                            if (q_rdata.echo) begin
                                load       = 1'b1;
                                kind_next  = OUT_CONSOLE;
                                byte_next  = q_rdata.data;
                                level_next = q_rdata.level;
                                last_next  = q_rdata.last;
                            end
                        end
                        OP_NEXT: begin
                            if (fill_reg == '0) begin
                                load      = 1'b1;
                                kind_next = OUT_EMPTY;
                            end else begin
                                ram_addr       = oldest_reg;
                                oldest_next    = (oldest_reg == LAST_A) ? '0 : oldest_reg + 1'b1;
                                fill_next      = fill_reg - 1'b1;
                                pend_kind_next = OUT_READ;
                                pend_wc_next   = '0;
                                state_next     = BK_READ;
                            end
                        end
                        OP_RECENT: begin
                            if (out_of_range) begin
                                load      = 1'b1;
                                kind_next = OUT_RANGE;
                                wc_next   = WC_W'(win_cnt);
                            end else begin
                                ram_addr       = recent_pos;
                                pend_kind_next = OUT_RECENT;
                                pend_wc_next   = WC_W'(win_cnt);
                                state_next     = BK_READ;
                            end
                        end
                        default: begin
                            recent_next = '0;
                        end
                    endcase
                end
            end
            BK_READ: begin
                load       = 1'b1;
                kind_next  = pend_kind_reg;
                byte_next  = ram_rdata;
                wc_next    = pend_wc_reg;
                state_next = BK_RUN;
            end
            default: begin
                state_next = BK_RUN;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Hold result payload and pending read info
    always_ff @(posedge aclk) begin
        pend_kind_reg <= pend_kind_next;
        pend_wc_reg   <= pend_wc_next;
        if (load) begin
            kind_reg  <= kind_next;
            byte_reg  <= byte_next;
            level_reg <= level_next;
            wc_reg    <= wc_next;
            last_reg  <= last_next;
        end
    end

    // Advance ring pointers and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_RUN;
            oldest_reg  <= '0;
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
            recent_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            wr_ptr_reg  <= wr_ptr_next;
            fill_reg    <= fill_next;
            recent_reg  <= recent_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_kind     = kind_reg;
    assign m_out_byte     = byte_reg;
    assign m_line_level   = level_reg;
    assign m_window_count = wc_reg;
    assign m_last         = last_reg;

endmodule
